// ===== src/lpr_pkg.sv =====
// Shared types and constants for the LED panel grid pixel remap block.
// Holds register codes, the panel table entry layout and the queue payloads.
// No dependencies.
`timescale 1ns / 1ps

package lpr_pkg;

  // Field widths fixed by the interface
  localparam int unsigned COORD_W     = 10;  // magnitude bits of a non-negative coordinate
  localparam int unsigned QUOT_W      = 7;   // panel row/column index from a coordinate
  localparam int unsigned LOC_W       = 7;   // position inside one panel
  localparam int unsigned RECIP_SHIFT = 20;  // fixed-point shift for divide-by-panel-size
  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned SRC_X_W     = 9;
  localparam int unsigned SRC_Y_W     = 7;
  localparam int unsigned CFG_IDX_W   = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_COLS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_ROWS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_PANELS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PARALLEL_CHAINS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BRIGHTNESS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_X        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_Y        = 3'd6;

  // Item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_ENTRY = 1'b1;

  // Panel rotation codes
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  typedef struct packed {
    logic [4:0] panel_cols;
    logic [4:0] panel_rows;
    logic [4:0] chain_panels;
    logic [2:0] parallel_chains;
    logic [7:0] max_brightness;
    logic       mirror_x;
    logic       mirror_y;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    panel_cols:      5'd1,
    panel_rows:      5'd1,
    chain_panels:    5'd1,
    parallel_chains: 3'd1,
    max_brightness:  8'd255,
    mirror_x:        1'b0,
    mirror_y:        1'b0
  };

  // Panel table entry: parallel in 7:6, order in 5:2, rotation in 1:0
  typedef struct packed {
    logic [1:0] par;
    logic [3:0] order;
    logic [1:0] rot;
  } entry_t;

  // Item passed from the front end to the back end
  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot;
    entry_t            entry;
    logic [LOC_W-1:0]  loc_x;
    logic [LOC_W-1:0]  loc_y;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
  } mid_t;

  // Result item
  typedef struct packed {
    logic [SRC_X_W-1:0] src_x;
    logic [SRC_Y_W-1:0] src_y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } res_t;

endpackage

// ===== src/lpr_fifo.sv =====
// Small register-based queue used between the remap stages and for the results.
// Depth must be a power of two; no package dependencies.
`timescale 1ns / 1ps

module lpr_fifo #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push_ok, pop_ok;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Store incoming entry
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Track fill level
  always_comb begin
    count_d = count_q;
    unique case ({push_ok, pop_ok})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      count_q <= count_d;
    end
  end

endmodule

// ===== src/lpr_front.sv =====
// Front end of the pixel remap: accepts items, drops out-of-range pixels,
// finds the panel index and the position inside the panel. Uses lpr_pkg.
`timescale 1ns / 1ps

module lpr_front #(
  parameter int unsigned PANEL_W    = 32,
  parameter int unsigned PANEL_H    = 32,
  parameter int unsigned MAX_PANELS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lpr_pkg::cfg_t       cfg_i,
  input  logic                push_i,
  output logic                full_o,
  input  logic                kind_i,
  input  logic signed [10:0]  pos_x_i,
  input  logic signed [10:0]  pos_y_i,
  input  logic [7:0]          red_in_i,
  input  logic [7:0]          green_in_i,
  input  logic [7:0]          blue_in_i,
  input  logic [5:0]          entry_index_i,
  input  logic [1:0]          entry_rotation_i,
  input  logic [3:0]          entry_order_i,
  input  logic [1:0]          entry_parallel_i,
  output logic                mid_push_o,
  output lpr_pkg::mid_t       mid_data_o,
  input  logic                mid_full_i
);

  localparam int unsigned CW      = lpr_pkg::COORD_W;
  localparam int unsigned QW      = lpr_pkg::QUOT_W;
  localparam int unsigned LW      = lpr_pkg::LOC_W;
  localparam int unsigned SH      = lpr_pkg::RECIP_SHIFT;
  localparam int unsigned PROD_W  = CW + SH;
  localparam int unsigned LIM_W   = 12;
  localparam int unsigned IDX_W   = 13;
  localparam int unsigned RECIP_X = ((1 << SH) + PANEL_W - 1) / PANEL_W;
  localparam int unsigned RECIP_Y = ((1 << SH) + PANEL_H - 1) / PANEL_H;
  localparam int unsigned IDX_LIMIT =
    (MAX_PANELS < lpr_pkg::TABLE_DEPTH) ? MAX_PANELS : lpr_pkg::TABLE_DEPTH;

  typedef struct packed {
    logic                       kind;
    logic [CW-1:0]              x;
    logic [CW-1:0]              y;
    logic [QW-1:0]              col;
    logic [QW-1:0]              row;
    logic [7:0]                 red;
    logic [7:0]                 green;
    logic [7:0]                 blue;
    logic [lpr_pkg::SLOT_W-1:0] slot;
    lpr_pkg::entry_t            entry;
  } f1_t;

  logic              in_range;
  logic [CW-1:0]     x_mag, y_mag;
  logic [LIM_W-1:0]  x_lim, y_lim;
  logic [PROD_W-1:0] x_prod, y_prod;
  f1_t               f1_d, f1_q;
  logic              f1_valid_q;
  logic              f1_keep;
  logic [IDX_W-1:0]  idx_sum;
  logic [CW-1:0]     col_base, row_base, loc_x_full, loc_y_full;

  // Range check against the canvas size
  assign x_mag    = pos_x_i[CW-1:0];
  assign y_mag    = pos_y_i[CW-1:0];
  assign x_lim    = LIM_W'(cfg_i.panel_cols) * LIM_W'(PANEL_W);
  assign y_lim    = LIM_W'(cfg_i.panel_rows) * LIM_W'(PANEL_H);
  assign in_range = !pos_x_i[10] && !pos_y_i[10] &&
                    (LIM_W'(x_mag) < x_lim) && (LIM_W'(y_mag) < y_lim);

  // Panel column and row by reciprocal multiply
  assign x_prod = PROD_W'(x_mag) * PROD_W'(RECIP_X);
  assign y_prod = PROD_W'(y_mag) * PROD_W'(RECIP_Y);

  always_comb begin
    f1_d.kind        = kind_i;
    f1_d.x           = x_mag;
    f1_d.y           = y_mag;
    f1_d.col         = x_prod[SH +: QW];
    f1_d.row         = y_prod[SH +: QW];
    f1_d.red         = red_in_i;
    f1_d.green       = green_in_i;
    f1_d.blue        = blue_in_i;
    f1_d.slot        = entry_index_i;
    f1_d.entry.rot   = entry_rotation_i;
    f1_d.entry.order = entry_order_i;
    f1_d.entry.par   = entry_parallel_i;
  end

  // Hold the stage only when a kept item cannot enter the queue
  assign full_o = f1_valid_q && f1_keep && mid_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else if (!full_o) begin
      f1_valid_q <= push_i && ((kind_i == lpr_pkg::KIND_ENTRY) || in_range);
    end
  end

  always_ff @(posedge clk_i) begin
    if (!full_o) begin
      f1_q <= f1_d;
    end
  end

  // Panel index and position inside the panel
  assign idx_sum    = IDX_W'(cfg_i.panel_cols) * IDX_W'(f1_q.row) + IDX_W'(f1_q.col);
  assign col_base   = CW'(f1_q.col) * CW'(PANEL_W);
  assign row_base   = CW'(f1_q.row) * CW'(PANEL_H);
  assign loc_x_full = f1_q.x - col_base;
  assign loc_y_full = f1_q.y - row_base;
  assign f1_keep    = (f1_q.kind == lpr_pkg::KIND_ENTRY) || (idx_sum < IDX_W'(IDX_LIMIT));

  // Transfer kept items into the queue
  assign mid_push_o = f1_valid_q && f1_keep && !mid_full_i;

  always_comb begin
    mid_data_o.kind  = f1_q.kind;
    mid_data_o.slot  = (f1_q.kind == lpr_pkg::KIND_ENTRY) ? f1_q.slot
                                                           : idx_sum[lpr_pkg::SLOT_W-1:0];
    mid_data_o.entry = f1_q.entry;
    mid_data_o.loc_x = loc_x_full[LW-1:0];
    mid_data_o.loc_y = loc_y_full[LW-1:0];
    mid_data_o.red   = f1_q.red;
    mid_data_o.green = f1_q.green;
    mid_data_o.blue  = f1_q.blue;
  end

  // A stalled item keeps its contents
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f1_valid_q && f1_keep && mid_full_i) |=> (f1_valid_q && $stable(f1_q)))
    else $error("front stage lost a stalled item");

  // Table writes are never dropped
  a_entry_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !full_o && (kind_i == lpr_pkg::KIND_ENTRY)) |=> (f1_valid_q && f1_keep))
    else $error("table write dropped in front stage");

  // Negative coordinates never enter the stage
  a_neg_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !full_o && (kind_i == lpr_pkg::KIND_PIXEL) && (pos_x_i[10] || pos_y_i[10]))
    |=> !f1_valid_q)
    else $error("negative coordinate was kept");

endmodule

// ===== src/lpr_back.sv =====
// Back end of the pixel remap: owns the panel table, applies rotation,
// chain offsets, mirrors and the brightness clamp. Uses lpr_pkg.
`timescale 1ns / 1ps

module lpr_back #(
  parameter int unsigned PANEL_W = 32,
  parameter int unsigned PANEL_H = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lpr_pkg::cfg_t cfg_i,
  input  lpr_pkg::mid_t mid_data_i,
  input  logic          mid_empty_i,
  output logic          mid_pop_o,
  output logic          out_push_o,
  output lpr_pkg::res_t out_data_o,
  input  logic          out_full_i
);

  localparam int unsigned LW     = lpr_pkg::LOC_W;
  localparam int unsigned XW     = lpr_pkg::SRC_X_W;
  localparam int unsigned YW     = lpr_pkg::SRC_Y_W;
  localparam bit          SQUARE = (PANEL_W == PANEL_H);

  typedef struct packed {
    logic [LW-1:0] loc_x;
    logic [LW-1:0] loc_y;
    logic [7:0]    red;
    logic [7:0]    green;
    logic [7:0]    blue;
  } pix_t;

  lpr_pkg::entry_t panel_mem [lpr_pkg::TABLE_DEPTH];
  lpr_pkg::entry_t entry_q;
  pix_t            pix_q;
  logic            b1_valid_q;
  logic            b1_ready;
  logic            entry_wr, pixel_rd;
  logic [LW-1:0]   rx, ry;
  logic [XW-1:0]   x_factor, x_base;
  logic [YW-1:0]   y_factor, y_base;

  function automatic logic [7:0] clamp(input logic [7:0] c, input logic [7:0] m);
    return (c > m) ? m : c;
  endfunction

  // Pop entries freely; pop pixels when the work stage can move
  assign b1_ready  = !b1_valid_q || !out_full_i;
  assign mid_pop_o = !mid_empty_i &&
                     ((mid_data_i.kind == lpr_pkg::KIND_ENTRY) || b1_ready);
  assign entry_wr  = mid_pop_o && (mid_data_i.kind == lpr_pkg::KIND_ENTRY);
  assign pixel_rd  = mid_pop_o && (mid_data_i.kind == lpr_pkg::KIND_PIXEL);

  // Panel table write port
  always_ff @(posedge clk_i) begin
    if (entry_wr) begin
      panel_mem[mid_data_i.slot] <= mid_data_i.entry;
    end
  end

  // Panel table registered read and pixel capture
  always_ff @(posedge clk_i) begin
    if (pixel_rd) begin
      entry_q     <= panel_mem[mid_data_i.slot];
      pix_q.loc_x <= mid_data_i.loc_x;
      pix_q.loc_y <= mid_data_i.loc_y;
      pix_q.red   <= mid_data_i.red;
      pix_q.green <= mid_data_i.green;
      pix_q.blue  <= mid_data_i.blue;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
    end else if (pixel_rd) begin
      b1_valid_q <= 1'b1;
    end else if (out_push_o) begin
      b1_valid_q <= 1'b0;
    end
  end

  // Rotate inside the panel; quarter turns only apply to square panels
  always_comb begin
    rx = pix_q.loc_x;
    ry = pix_q.loc_y;
    unique case (entry_q.rot)
      lpr_pkg::ROT_0: begin
        rx = pix_q.loc_x;
      end
      lpr_pkg::ROT_90: begin
        if (SQUARE) begin
          rx = LW'(PANEL_H - 1) - pix_q.loc_y;
          ry = pix_q.loc_x;
        end
      end
      lpr_pkg::ROT_180: begin
        rx = LW'(PANEL_W - 1) - pix_q.loc_x;
        ry = LW'(PANEL_H - 1) - pix_q.loc_y;
      end
      lpr_pkg::ROT_270: begin
        if (SQUARE) begin
          rx = pix_q.loc_y;
          ry = LW'(PANEL_W - 1) - pix_q.loc_x;
        end
      end
    endcase
  end

  // Chain and parallel offsets with mirrors folded into the panel factor
  assign x_factor = cfg_i.mirror_x ? (XW'(entry_q.order) + XW'(1))
                                   : (XW'(cfg_i.chain_panels) - XW'(1) - XW'(entry_q.order));
  assign x_base   = x_factor * XW'(PANEL_W);
  assign y_factor = cfg_i.mirror_y ? (YW'(cfg_i.parallel_chains) - YW'(entry_q.par))
                                   : YW'(entry_q.par);
  assign y_base   = y_factor * YW'(PANEL_H);

  always_comb begin
    out_data_o.src_x = cfg_i.mirror_x ? (x_base - XW'(rx) - XW'(1)) : (x_base + XW'(rx));
    out_data_o.src_y = cfg_i.mirror_y ? (y_base - YW'(ry) - YW'(1)) : (y_base + YW'(ry));
    out_data_o.red   = clamp(pix_q.red, cfg_i.max_brightness);
    out_data_o.green = clamp(pix_q.green, cfg_i.max_brightness);
    out_data_o.blue  = clamp(pix_q.blue, cfg_i.max_brightness);
  end

  // Transfer the finished pixel to the result queue
  assign out_push_o = b1_valid_q && !out_full_i;

  // A stalled pixel stays in the work stage
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b1_valid_q && out_full_i) |=> b1_valid_q)
    else $error("back stage dropped a stalled pixel");

  // A popped pixel occupies the work stage next cycle
  a_pixel_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_rd |=> b1_valid_q)
    else $error("popped pixel did not reach the work stage");

  // A pixel only enters when the previous one leaves
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pixel_rd && b1_valid_q) |-> out_push_o)
    else $error("pixel overwrote an undelivered pixel");

endmodule

// ===== src/led_panel_grid_pixel_remap_top.sv =====
// A kept pixel passes the front stage register, the middle queue, the back work stage and the result queue.
// Throughput: one item per cycle while full is low; table writes and dropped pixels give no result.
// The front end and back end are split by a 4-entry queue; results wait in a 2-entry queue.
// Reset clears the configuration to its defaults and empties both queues.
// The panel table is not cleared by reset; its entries are undefined until written.
`timescale 1ns / 1ps

// Top level of the LED panel grid pixel remap block.
// Depends on lpr_pkg, lpr_fifo, lpr_front and lpr_back.

module led_panel_grid_pixel_remap_top #(
  parameter int unsigned PANEL_W    = 32,
  parameter int unsigned PANEL_H    = 32,
  parameter int unsigned MAX_PANELS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lpr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic                          kind_i,
  input  logic signed [10:0]            pos_x_i,
  input  logic signed [10:0]            pos_y_i,
  input  logic [7:0]                    red_in_i,
  input  logic [7:0]                    green_in_i,
  input  logic [7:0]                    blue_in_i,
  input  logic [5:0]                    entry_index_i,
  input  logic [1:0]                    entry_rotation_i,
  input  logic [3:0]                    entry_order_i,
  input  logic [1:0]                    entry_parallel_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [8:0]                    src_x_o,
  output logic [6:0]                    src_y_o,
  output logic [7:0]                    red_out_o,
  output logic [7:0]                    green_out_o,
  output logic [7:0]                    blue_out_o
);

  localparam int unsigned MID_W = $bits(lpr_pkg::mid_t);
  localparam int unsigned RES_W = $bits(lpr_pkg::res_t);

  lpr_pkg::cfg_t cfg_q;
  lpr_pkg::mid_t mid_in, mid_out;
  lpr_pkg::res_t res_in, res_out;
  logic          mid_push, mid_full, mid_pop, mid_empty;
  logic          res_push, res_full;
  logic [MID_W-1:0] mid_out_vec;
  logic [RES_W-1:0] res_out_vec;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= lpr_pkg::CFG_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lpr_pkg::CFG_PANEL_COLS:      cfg_q.panel_cols      <= cfg_data_i[4:0];
        lpr_pkg::CFG_PANEL_ROWS:      cfg_q.panel_rows      <= cfg_data_i[4:0];
        lpr_pkg::CFG_CHAIN_PANELS:    cfg_q.chain_panels    <= cfg_data_i[4:0];
        lpr_pkg::CFG_PARALLEL_CHAINS: cfg_q.parallel_chains <= cfg_data_i[2:0];
        lpr_pkg::CFG_MAX_BRIGHTNESS:  cfg_q.max_brightness  <= cfg_data_i;
        lpr_pkg::CFG_MIRROR_X:        cfg_q.mirror_x        <= cfg_data_i[0];
        lpr_pkg::CFG_MIRROR_Y:        cfg_q.mirror_y        <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Accept and classify items
  lpr_front #(
    .PANEL_W    (PANEL_W),
    .PANEL_H    (PANEL_H),
    .MAX_PANELS (MAX_PANELS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .push_i           (push),
    .full_o           (full),
    .kind_i           (kind_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .red_in_i         (red_in_i),
    .green_in_i       (green_in_i),
    .blue_in_i        (blue_in_i),
    .entry_index_i    (entry_index_i),
    .entry_rotation_i (entry_rotation_i),
    .entry_order_i    (entry_order_i),
    .entry_parallel_i (entry_parallel_i),
    .mid_push_o       (mid_push),
    .mid_data_o       (mid_in),
    .mid_full_i       (mid_full)
  );

  // Decouple front and back
  lpr_fifo #(
    .DEPTH (4),
    .WIDTH (MID_W)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_out_vec),
    .empty_o (mid_empty)
  );

  assign mid_out = lpr_pkg::mid_t'(mid_out_vec);

  // Table access and coordinate remap
  lpr_back #(
    .PANEL_W (PANEL_W),
    .PANEL_H (PANEL_H)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .mid_data_i  (mid_out),
    .mid_empty_i (mid_empty),
    .mid_pop_o   (mid_pop),
    .out_push_o  (res_push),
    .out_data_o  (res_in),
    .out_full_i  (res_full)
  );

  // Hold results until taken
  lpr_fifo #(
    .DEPTH (2),
    .WIDTH (RES_W)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out_vec),
    .empty_o (empty)
  );

  assign res_out     = lpr_pkg::res_t'(res_out_vec);
  assign src_x_o     = res_out.src_x;
  assign src_y_o     = res_out.src_y;
  assign red_out_o   = res_out.red;
  assign green_out_o = res_out.green;
  assign blue_out_o  = res_out.blue;

endmodule

// ===== test/led_panel_grid_pixel_remap_top_test.sv =====
// Self-checking testbench for led_panel_grid_pixel_remap_top: panel table writes, pixel remap,
// mirrors, clamping and drops, checked against an in-bench predictor over randomized handshakes.
// Depends on lpr_pkg and the RTL of led_panel_grid_pixel_remap_top.
`timescale 1ns / 1ps

module led_panel_grid_pixel_remap_top_test;

  localparam int PW           = 32;
  localparam int PH           = 32;
  localparam int MAXP         = 64;
  localparam bit SQUARE       = (PW == PH);
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 94;

  // One input item as seen on the push side
  typedef struct packed {
    logic               kind;
    logic signed [10:0] pos_x;
    logic signed [10:0] pos_y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [5:0]         slot;
    lpr_pkg::entry_t    entry;
  } item_t;

  // Predicts remapped pixels and holds them until they come out of the block
  class pixel_remap_checker;
    lpr_pkg::cfg_t   regs;
    lpr_pkg::entry_t panel_entries [lpr_pkg::TABLE_DEPTH];
    lpr_pkg::res_t   expected_pixels [$];
    int unsigned     errors;

    function new();
      regs   = lpr_pkg::CFG_RESET;
      errors = 0;
    endfunction

    function void set_reg(logic [lpr_pkg::CFG_IDX_W-1:0] idx, logic [7:0] data);
      unique case (idx)
        lpr_pkg::CFG_PANEL_COLS:      regs.panel_cols      = data[4:0];
        lpr_pkg::CFG_PANEL_ROWS:      regs.panel_rows      = data[4:0];
        lpr_pkg::CFG_CHAIN_PANELS:    regs.chain_panels    = data[4:0];
        lpr_pkg::CFG_PARALLEL_CHAINS: regs.parallel_chains = data[2:0];
        lpr_pkg::CFG_MAX_BRIGHTNESS:  regs.max_brightness  = data;
        lpr_pkg::CFG_MIRROR_X:        regs.mirror_x        = data[0];
        lpr_pkg::CFG_MIRROR_Y:        regs.mirror_y        = data[0];
        default: ;
      endcase
    endfunction

    function logic [7:0] clamp(logic [7:0] c);
      return (c > regs.max_brightness) ? regs.max_brightness : c;
    endfunction

    // Note an accepted item: store a table entry or predict a kept pixel
    function void take_item(item_t it);
      int              x, y, lx, ly, tmp, idx, xi, yi;
      lpr_pkg::entry_t e;
      lpr_pkg::res_t   r;
      if (it.kind == lpr_pkg::KIND_ENTRY) begin
        panel_entries[it.slot] = it.entry;
        return;
      end
      x = int'($signed(it.pos_x));
      y = int'($signed(it.pos_y));
      if (x < 0 || y < 0 || x >= int'(regs.panel_cols) * PW ||
          y >= int'(regs.panel_rows) * PH)
        return;
      idx = int'(regs.panel_cols) * (y / PH) + x / PW;
      if (idx >= MAXP || idx >= int'(lpr_pkg::TABLE_DEPTH))
        return;
      e  = panel_entries[idx];
      lx = x % PW;
      ly = y % PH;
      // Rotate inside the panel; quarter turns only apply to square panels
      unique case (e.rot)
        lpr_pkg::ROT_90: if (SQUARE) begin
          tmp = lx;
          lx  = PH - 1 - ly;
          ly  = tmp;
        end
        lpr_pkg::ROT_180: begin
          lx = PW - 1 - lx;
          ly = PH - 1 - ly;
        end
        lpr_pkg::ROT_270: if (SQUARE) begin
          tmp = ly;
          ly  = PW - 1 - lx;
          lx  = tmp;
        end
        default: ;
      endcase
      xi = (int'(regs.chain_panels) - 1 - int'(e.order)) * PW + lx;
      if (regs.mirror_x)
        xi = int'(regs.chain_panels) * PW - xi - 1;
      yi = int'(e.par) * PH + ly;
      if (regs.mirror_y)
        yi = int'(regs.parallel_chains) * PH - yi - 1;
      r.src_x = xi[lpr_pkg::SRC_X_W-1:0];
      r.src_y = yi[lpr_pkg::SRC_Y_W-1:0];
      r.red   = clamp(it.red);
      r.green = clamp(it.green);
      r.blue  = clamp(it.blue);
      expected_pixels.push_back(r);
    endfunction

    function void compare_field(string name, logic [8:0] want, logic [8:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    // Check a popped result against the oldest prediction
    function void check_pixel(lpr_pkg::res_t got);
      lpr_pkg::res_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual src_x %0d src_y %0d",
                 $time, got.src_x, got.src_y);
        return;
      end
      want = expected_pixels.pop_front();
      compare_field("src_x", want.src_x, got.src_x);
      compare_field("src_y", 9'(want.src_y), 9'(got.src_y));
      compare_field("red_out", 9'(want.red), 9'(got.red));
      compare_field("green_out", 9'(want.green), 9'(got.green));
      compare_field("blue_out", 9'(want.blue), 9'(got.blue));
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [lpr_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [7:0]                    cfg_data_i;
  logic                          push;
  logic                          full;
  logic                          kind_i;
  logic signed [10:0]            pos_x_i;
  logic signed [10:0]            pos_y_i;
  logic [7:0]                    red_in_i;
  logic [7:0]                    green_in_i;
  logic [7:0]                    blue_in_i;
  logic [5:0]                    entry_index_i;
  logic [1:0]                    entry_rotation_i;
  logic [3:0]                    entry_order_i;
  logic [1:0]                    entry_parallel_i;
  logic                          empty;
  logic                          pop;
  logic [8:0]                    src_x_o;
  logic [6:0]                    src_y_o;
  logic [7:0]                    red_out_o;
  logic [7:0]                    green_out_o;
  logic [7:0]                    blue_out_o;

  pixel_remap_checker checker_h;
  bit                 slot_written [lpr_pkg::TABLE_DEPTH];
  int                 cols_now;
  int                 rows_now;
  bit                 hold_req;
  bit                 no_idle;
  int unsigned        cycle_count;

  led_panel_grid_pixel_remap_top #(
    .PANEL_W(PW),
    .PANEL_H(PH),
    .MAX_PANELS(MAXP)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .push(push),
    .full(full),
    .kind_i(kind_i),
    .pos_x_i(pos_x_i),
    .pos_y_i(pos_y_i),
    .red_in_i(red_in_i),
    .green_in_i(green_in_i),
    .blue_in_i(blue_in_i),
    .entry_index_i(entry_index_i),
    .entry_rotation_i(entry_rotation_i),
    .entry_order_i(entry_order_i),
    .entry_parallel_i(entry_parallel_i),
    .empty(empty),
    .pop(pop),
    .src_x_o(src_x_o),
    .src_y_o(src_y_o),
    .red_out_o(red_out_o),
    .green_out_o(green_out_o),
    .blue_out_o(blue_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, checker_h.pending());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Capture every input transfer
  always @(posedge clk_i) begin
    item_t seen;
    if (rst_ni && push && !full) begin
      seen.kind  = kind_i;
      seen.pos_x = pos_x_i;
      seen.pos_y = pos_y_i;
      seen.red   = red_in_i;
      seen.green = green_in_i;
      seen.blue  = blue_in_i;
      seen.slot  = entry_index_i;
      seen.entry = '{par: entry_parallel_i, order: entry_order_i, rot: entry_rotation_i};
      checker_h.take_item(seen);
    end
  end

  // Check every result transfer
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty)
      checker_h.check_pixel('{src_x: src_x_o, src_y: src_y_o, red: red_out_o,
                              green: green_out_o, blue: blue_out_o});
  end

  // Receiver: random pop bursts, one long hold-off on request, steady at the end
  initial begin
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (no_idle) begin
        pop <= 1'b1;
        @(posedge clk_i);
      end else begin
        pop <= ($urandom_range(0, 1) == 1);
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
    end
  end

  // Offer one item and hold it until the transfer; maybe idle afterwards
  task automatic send(item_t it);
    kind_i           <= it.kind;
    pos_x_i          <= it.pos_x;
    pos_y_i          <= it.pos_y;
    red_in_i         <= it.red;
    green_in_i       <= it.green;
    blue_in_i        <= it.blue;
    entry_index_i    <= it.slot;
    entry_rotation_i <= it.entry.rot;
    entry_order_i    <= it.entry.order;
    entry_parallel_i <= it.entry.par;
    push             <= 1'b1;
    do @(posedge clk_i); while (full);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  function automatic item_t noise_item();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[$bits(item_t)-1:0];
  endfunction

  task automatic send_entry(int slot, logic [1:0] rot, int order, int par);
    item_t it;
    it             = noise_item();
    it.kind        = lpr_pkg::KIND_ENTRY;
    it.slot        = slot[5:0];
    it.entry.rot   = rot;
    it.entry.order = order[3:0];
    it.entry.par   = par[1:0];
    slot_written[slot] = 1'b1;
    send(it);
  endtask

  task automatic send_pixel(int x, int y, int r, int g, int b);
    item_t it;
    it       = noise_item();
    it.kind  = lpr_pkg::KIND_PIXEL;
    it.pos_x = x[10:0];
    it.pos_y = y[10:0];
    it.red   = r[7:0];
    it.green = g[7:0];
    it.blue  = b[7:0];
    send(it);
  endtask

  // Mostly in-range pixels; a pixel that would read a blank slot fills it instead
  function automatic item_t next_random_item();
    item_t it;
    int    w, h, x, y, idx;
    it = noise_item();
    w  = cols_now * PW;
    h  = rows_now * PH;
    if ($urandom_range(0, 99) < 20) begin
      it.kind = lpr_pkg::KIND_ENTRY;
    end else begin
      it.kind = lpr_pkg::KIND_PIXEL;
      if (w > 0 && h > 0 && $urandom_range(0, 99) >= 12) begin
        it.pos_x = 11'($urandom_range(0, w - 1));
        it.pos_y = 11'($urandom_range(0, h - 1));
      end
      x = int'($signed(it.pos_x));
      y = int'($signed(it.pos_y));
      if (x >= 0 && y >= 0 && x < w && y < h) begin
        idx = cols_now * (y / PH) + x / PW;
        if (idx < int'(lpr_pkg::TABLE_DEPTH) && idx < MAXP && !slot_written[idx]) begin
          it.kind = lpr_pkg::KIND_ENTRY;
          it.slot = idx[5:0];
        end
      end
    end
    if (it.kind == lpr_pkg::KIND_ENTRY)
      slot_written[it.slot] = 1'b1;
    return it;
  endfunction

  // Stop pushing, let the pipe empty and give dropped items time to leave
  task automatic settle();
    push <= 1'b0;
    while (checker_h.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_transfer(logic [lpr_pkg::CFG_IDX_W-1:0] idx, logic [7:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    checker_h.set_reg(idx, data);
  endtask

  // Write all seven registers back to back, then drop valid
  task automatic write_config(lpr_pkg::cfg_t c);
    cfg_transfer(lpr_pkg::CFG_PANEL_COLS, 8'(c.panel_cols));
    cfg_transfer(lpr_pkg::CFG_PANEL_ROWS, 8'(c.panel_rows));
    cfg_transfer(lpr_pkg::CFG_CHAIN_PANELS, 8'(c.chain_panels));
    cfg_transfer(lpr_pkg::CFG_PARALLEL_CHAINS, 8'(c.parallel_chains));
    cfg_transfer(lpr_pkg::CFG_MAX_BRIGHTNESS, c.max_brightness);
    cfg_transfer(lpr_pkg::CFG_MIRROR_X, 8'(c.mirror_x));
    cfg_transfer(lpr_pkg::CFG_MIRROR_Y, 8'(c.mirror_y));
    cfg_valid_i <= 1'b0;
    cols_now = int'(c.panel_cols);
    rows_now = int'(c.panel_rows);
  endtask

  function automatic lpr_pkg::cfg_t random_settings();
    lpr_pkg::cfg_t c;
    c.panel_cols      = 5'($urandom_range(1, 16));
    c.panel_rows      = 5'($urandom_range(1, 16));
    c.chain_panels    = 5'($urandom_range(1, 16));
    c.parallel_chains = 3'($urandom_range(1, 4));
    c.max_brightness  = 8'($urandom_range(0, 255));
    c.mirror_x        = 1'($urandom_range(0, 1));
    c.mirror_y        = 1'($urandom_range(0, 1));
    return c;
  endfunction

  initial begin
    lpr_pkg::cfg_t phase_cfg;
    checker_h        = new();
    cols_now         = int'(lpr_pkg::CFG_RESET.panel_cols);
    rows_now         = int'(lpr_pkg::CFG_RESET.panel_rows);
    hold_req         = 1'b0;
    no_idle          = 1'b0;
    cycle_count      = 0;
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = '0;
    cfg_data_i       = '0;
    push             = 1'b0;
    pop              = 1'b0;
    kind_i           = lpr_pkg::KIND_PIXEL;
    pos_x_i          = '0;
    pos_y_i          = '0;
    red_in_i         = '0;
    green_in_i       = '0;
    blue_in_i        = '0;
    entry_index_i    = '0;
    entry_rotation_i = lpr_pkg::ROT_0;
    entry_order_i    = '0;
    entry_parallel_i = '0;
    for (int i = 0; i < int'(lpr_pkg::TABLE_DEPTH); i++)
      slot_written[i] = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: corners, drops, every rotation, chain order past the chain length
    send_entry(0, lpr_pkg::ROT_0, 0, 0);
    send_pixel(0, 0, 255, 0, 128);
    send_pixel(31, 31, 0, 255, 1);
    send_pixel(32, 0, 10, 20, 30);
    send_pixel(0, 32, 10, 20, 30);
    send_pixel(-1, 0, 10, 20, 30);
    send_pixel(0, -1024, 10, 20, 30);
    send_pixel(1023, 1023, 10, 20, 30);
    send_entry(0, lpr_pkg::ROT_90, 0, 0);
    send_pixel(3, 5, 1, 2, 3);
    send_entry(0, lpr_pkg::ROT_180, 0, 0);
    send_pixel(3, 5, 4, 5, 6);
    send_entry(0, lpr_pkg::ROT_270, 0, 0);
    send_pixel(3, 5, 7, 8, 9);
    send_entry(0, lpr_pkg::ROT_0, 15, 3);
    send_pixel(31, 31, 255, 255, 255);
    send_entry(63, lpr_pkg::ROT_270, 15, 3);

    // Largest grid with both mirrors and full clamping; panel index past the table
    settle();
    write_config('{panel_cols: 5'd16, panel_rows: 5'd16, chain_panels: 5'd16,
                   parallel_chains: 3'd4, max_brightness: 8'd0,
                   mirror_x: 1'b1, mirror_y: 1'b1});
    send_pixel(0, 0, 255, 128, 1);
    send_pixel(485, 103, 200, 100, 0);
    send_pixel(0, 128, 1, 1, 1);
    send_pixel(511, 511, 1, 1, 1);

    // Zero panel columns drop every pixel
    settle();
    write_config('{panel_cols: 5'd0, panel_rows: 5'd1, chain_panels: 5'd1,
                   parallel_chains: 3'd1, max_brightness: 8'd255,
                   mirror_x: 1'b0, mirror_y: 1'b0});
    send_pixel(0, 0, 1, 1, 1);

    // Random phases, each under its own settings
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: phase_cfg = '{panel_cols: 5'd16, panel_rows: 5'd16, chain_panels: 5'd16,
                         parallel_chains: 3'd4, max_brightness: 8'd255,
                         mirror_x: 1'b1, mirror_y: 1'b1};
        1: phase_cfg = '{panel_cols: 5'd2, panel_rows: 5'd2, chain_panels: 5'd2,
                         parallel_chains: 3'd2, max_brightness: 8'd200,
                         mirror_x: 1'b0, mirror_y: 1'b1};
        2: phase_cfg = '{panel_cols: 5'd1, panel_rows: 5'd1, chain_panels: 5'd1,
                         parallel_chains: 3'd1, max_brightness: 8'd0,
                         mirror_x: 1'b0, mirror_y: 1'b0};
        default: phase_cfg = random_settings();
      endcase
      write_config(phase_cfg);
      // Stall the receiver while items keep coming, so the block backs up
      if (p == 1)
        hold_req = 1'b1;
      if (p == PHASES - 1)
        no_idle = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++)
        send(next_random_item());
    end

    push <= 1'b0;
    while (checker_h.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (checker_h.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
